FILE: src/adsr_pkg.sv
// shared types, constants and codes for the adsr envelope level block
package adsr_pkg;

	localparam int TIME_BITS    = 16;
	localparam int LEVEL_BITS   = 8;
	localparam int ELAPSED_BITS = TIME_BITS + 2;
	localparam int NUM_BITS     = LEVEL_BITS + TIME_BITS + 1;
	localparam int CNT_BITS     = $clog2(NUM_BITS);
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ATTACK  = 2'd0,
		CFG_DECAY   = 2'd1,
		CFG_RELEASE = 2'd2,
		CFG_SUSTAIN = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ATTACK  = 2'd1,
		PH_DECAY   = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_POST,
		ST_BDIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [NUM_BITS-1:0]  num;
		logic [TIME_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [NUM_BITS-1:0] quot;
	} div_rsp_t;

endpackage

FILE: src/adsr_div.sv
// serial restoring divider, one quotient bit per cycle
module adsr_div
	import adsr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0]  work_q;
	logic [TIME_BITS-1:0] den_q;
	logic [TIME_BITS:0]   trial;
	logic                 fits;

	assign trial = {rem_q, work_q[NUM_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_BITS'(NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			work_q <= req.num;
			den_q  <= req.den;
		end else if (busy_q) begin
			rem_q  <= fits ? TIME_BITS'(trial - {1'b0, den_q}) : trial[TIME_BITS-1:0];
			work_q <= {work_q[NUM_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = work_q;

endmodule

FILE: src/adsr_envelope_level.sv
// adsr envelope level generator with a shared multiplier and serial divider
//
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    action, velocity
// out      output     out_valid / out_stall  level, phase
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each envelope evaluation that falls in a live segment runs one 25-step
// pass of the serial divider, and a note on needs up to three passes (old
// level, time rewind, new level).
// in_stall is high from acceptance until the result enters the output register.
// the next transaction is taken while that result still waits on out_stall.
// reset clears config, elapsed time, peak level and control state.
module adsr_envelope_level
	import adsr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    action,
	input  logic [LEVEL_BITS-1:0]   velocity,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [LEVEL_BITS-1:0]   level,
	output logic [1:0]              phase,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [TIME_BITS-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic [TIME_BITS-1:0]    attack_q, decay_q, release_q;
	logic [LEVEL_BITS-1:0]   sustain_q;
	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [LEVEL_BITS-1:0]   peak_q;
	logic [LEVEL_BITS-1:0]   vel_q;
	logic                    final_q;
	logic                    start_q;
	logic [NUM_BITS-1:0]     num_q;
	logic [TIME_BITS-1:0]    den_q;
	phase_t                  seg_q;
	logic                    sub_q;
	logic [LEVEL_BITS-1:0]   lvl_q;
	phase_t                  ph_q;
	logic                    out_valid_q;
	logic [LEVEL_BITS-1:0]   level_q;
	phase_t                  phase_q;

	logic                    in_fire;
	logic                    out_load;
	logic                    seg_zero;
	phase_t                  seg;
	logic                    sub;
	logic [LEVEL_BITS-1:0]   mx;
	logic [TIME_BITS-1:0]    my;
	logic [TIME_BITS-1:0]    seg_den;
	logic [TIME_BITS-1:0]    bias;
	logic [LEVEL_BITS+TIME_BITS-1:0] prod;
	logic [TIME_BITS:0]      ad;
	logic [ELAPSED_BITS-1:0] adr;
	logic [ELAPSED_BITS-1:0] k_dec;
	logic [ELAPSED_BITS-1:0] k_rel;
	logic [LEVEL_BITS-1:0]   p_minus_s;
	logic [LEVEL_BITS-1:0]   s_minus_p;
	logic [LEVEL_BITS-1:0]   q_lvl;
	logic [LEVEL_BITS-1:0]   new_lvl;
	logic [ELAPSED_BITS-1:0] back_t;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			release_q <= '0;
			sustain_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ATTACK:  attack_q  <= cfg_data;
				CFG_DECAY:   decay_q   <= cfg_data;
				CFG_RELEASE: release_q <= cfg_data;
				CFG_SUSTAIN: sustain_q <= cfg_data[LEVEL_BITS-1:0];
				default:     ;
			endcase
		end
	end

	// segment selection
	assign ad        = {1'b0, attack_q} + {1'b0, decay_q};
	assign adr       = ELAPSED_BITS'(ad) + ELAPSED_BITS'(release_q);
	assign k_dec     = ELAPSED_BITS'(ad) - elapsed_q;
	assign k_rel     = adr - elapsed_q;
	assign sub       = peak_q < sustain_q;
	assign p_minus_s = peak_q - sustain_q;
	assign s_minus_p = sustain_q - peak_q;

	always_comb begin
		seg_zero = 1'b0;
		seg      = PH_IDLE;
		mx       = '0;
		my       = '0;
		seg_den  = '0;
		bias     = '0;
		if (peak_q == '0) begin
			seg_zero = 1'b1;
		end else if (elapsed_q < ELAPSED_BITS'(attack_q)) begin
			seg     = PH_ATTACK;
			mx      = peak_q;
			my      = elapsed_q[TIME_BITS-1:0];
			seg_den = attack_q;
		end else if (elapsed_q < ELAPSED_BITS'(ad)) begin
			seg     = PH_DECAY;
			mx      = sub ? s_minus_p : p_minus_s;
			my      = k_dec[TIME_BITS-1:0];
			seg_den = decay_q;
			bias    = sub ? TIME_BITS'(decay_q - 1'b1) : '0;
		end else if (elapsed_q < adr) begin
			seg     = PH_RELEASE;
			mx      = sustain_q;
			my      = k_rel[TIME_BITS-1:0];
			seg_den = release_q;
		end else begin
			seg_zero = 1'b1;
		end
	end

	// shared multiplier: envelope numerator or time rewind numerator
	always_comb begin
		if (state_q == ST_POST) begin
			prod = lvl_q * attack_q;
		end else begin
			prod = mx * my;
		end
	end

	// level from quotient
	assign q_lvl = div_rsp.quot[LEVEL_BITS-1:0];

	always_comb begin
		case (seg_q)
			PH_DECAY: new_lvl = sub_q ? sustain_q - q_lvl : sustain_q + q_lvl;
			default:  new_lvl = q_lvl;
		endcase
	end

	assign back_t = (div_rsp.quot[NUM_BITS-1:ELAPSED_BITS] != '0) ? '1
		: div_rsp.quot[ELAPSED_BITS-1:0];

	assign div_req.start = start_q;
	assign div_req.num   = num_q;
	assign div_req.den   = den_q;

	adsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	assign in_fire  = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = seg_zero ? ST_POST : ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (lvl_q != '0 && peak_q != '0) begin
					state_d = ST_BDIV;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_BDIV: begin
				if (div_rsp.done) begin
					state_d = ST_EVAL;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			peak_q    <= '0;
			start_q   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (in_fire && !action && elapsed_q != '1) begin
				elapsed_q <= elapsed_q + 1'b1;
			end
			if (state_q == ST_EVAL && !seg_zero) begin
				start_q <= 1'b1;
			end
			if (state_q == ST_POST && !final_q) begin
				if (lvl_q != '0 && peak_q != '0) begin
					start_q <= 1'b1;
				end else begin
					elapsed_q <= '0;
					peak_q    <= vel_q;
				end
			end
			if (state_q == ST_BDIV && div_rsp.done) begin
				elapsed_q <= back_t;
				peak_q    <= vel_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			vel_q   <= velocity;
			final_q <= !action;
		end
		if (state_q == ST_EVAL) begin
			num_q <= NUM_BITS'(prod) + NUM_BITS'(bias);
			den_q <= seg_den;
			seg_q <= seg;
			sub_q <= sub;
			if (seg_zero) begin
				lvl_q <= '0;
				ph_q  <= PH_IDLE;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			lvl_q <= new_lvl;
			ph_q  <= seg_q;
		end
		if (state_q == ST_POST && !final_q) begin
			num_q   <= NUM_BITS'(prod);
			den_q   <= TIME_BITS'(peak_q);
			final_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q <= lvl_q;
			phase_q <= ph_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign phase     = phase_q;

endmodule

FILE: src/adsr_chk.sv
// port checker for the adsr envelope level block, bound to the top level
module adsr_chk
	import adsr_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [LEVEL_BITS-1:0]   level,
	input logic [1:0]              phase
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level) && $stable(phase))
		else $error("output transaction changed while stalled");

	// idle or finished envelope reports zero level
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase_t'(phase) == PH_IDLE |-> level == '0)
		else $error("idle phase with nonzero level");

	// an accepted transaction keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted transaction");

endmodule

bind adsr_envelope_level adsr_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.level     (level),
	.phase     (phase)
);
